### rtl/core/tpi_pkg.sv
// Shared types and codes for the triangle/plane intersection block.
package tpi_pkg;

    typedef logic signed [31:0] tpi_word_t;

    // Corner: x, y, z, u, v in field order 0..4.
    typedef tpi_word_t [4:0] tpi_corner_t;
    // Plane coefficients indexed by register index.
    typedef tpi_word_t [3:0] tpi_plane_t;

    localparam int NUM_FIELDS = 5;

    localparam logic [1:0] REG_PLANE_A = 2'd0;
    localparam logic [1:0] REG_PLANE_B = 2'd1;
    localparam logic [1:0] REG_PLANE_C = 2'd2;
    localparam logic [1:0] REG_PLANE_D = 2'd3;

    localparam logic [1:0] EDGE_01 = 2'd0;
    localparam logic [1:0] EDGE_12 = 2'd1;
    localparam logic [1:0] EDGE_20 = 2'd2;

    localparam logic [1:0] CORNER_0 = 2'd0;
    localparam logic [1:0] CORNER_1 = 2'd1;
    localparam logic [1:0] CORNER_2 = 2'd2;

    typedef struct packed {
        logic [1:0]  edge_id;
        tpi_corner_t s;
        tpi_corner_t e;
    } tpi_job_t;

    typedef struct packed {
        logic        hit;
        logic [1:0]  edge_res;
        tpi_corner_t cut;
        logic [1:0]  shared_corner;
        logic        two_hits;
        logic        last;
    } tpi_res_t;

endpackage

### rtl/core/tpi_fifo.sv
// Small register FIFO used for the job queue and the result queue.
module tpi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end
endmodule

### rtl/core/tpi_front.sv
// Front end: collects corners and turns them into edge jobs.
module tpi_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  tpi_pkg::tpi_corner_t corner,
    output logic               jq_push,
    output tpi_pkg::tpi_job_t  jq_job,
    input  logic               jq_full
);
    import tpi_pkg::*;

    logic [1:0]  cnt_reg;
    logic        pend2_reg;
    tpi_corner_t first_reg;
    tpi_corner_t prev_reg;
    logic        accept;

    assign full   = pend2_reg || jq_full;
    assign accept = push && !full;

    always_comb
    begin
        jq_push = 1'b0;
        jq_job  = '{edge_id: EDGE_01, s: first_reg, e: corner};
        if (pend2_reg)
        begin
            jq_push = !jq_full;
            jq_job  = '{edge_id: EDGE_20, s: prev_reg, e: first_reg};
        end
        else if (accept && cnt_reg == 2'd1)
        begin
            jq_push = 1'b1;
        end
        else if (accept && cnt_reg == 2'd2)
        begin
            jq_push = 1'b1;
            jq_job  = '{edge_id: EDGE_12, s: prev_reg, e: corner};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= 2'd0;
            pend2_reg <= 1'b0;
        end
        else
        begin
            if (pend2_reg && !jq_full)
            begin
                pend2_reg <= 1'b0;
            end
            if (accept)
            begin
                cnt_reg <= (cnt_reg == 2'd2) ? 2'd0 : cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                begin
                    pend2_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_reg <= corner;
            if (cnt_reg == 2'd0)
            begin
                first_reg <= corner;
            end
        end
    end
endmodule

### rtl/core/tpi_back.sv
// Back end: plane evaluation, iterative t division, interpolation, result sequencing.
module tpi_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tpi_pkg::tpi_plane_t plane,
    input  logic                jq_empty,
    input  tpi_pkg::tpi_job_t   jq_job,
    output logic                jq_pop,
    input  logic                of_full,
    output logic                of_push,
    output tpi_pkg::tpi_res_t   of_res
);
    import tpi_pkg::*;

    localparam int PW  = 68;                 // plane value and divider width
    localparam int TW  = FRAC_BITS + 1;      // t, range 0..2^FRAC_BITS
    localparam int PRW = 33 + TW + 1;        // edge delta times t
    localparam int SW  = PRW + 1;            // corner plus rounded offset
    localparam int CW  = $clog2(FRAC_BITS + 1);
    localparam logic signed [SW-1:0] SAT_MAX = SW'(2147483647);
    localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_PREP, S_CHECK, S_DIV, S_INTERP, S_DECIDE, S_EMIT
    } state_t;

    state_t              state_reg;
    logic [2:0]          step_reg;
    logic [CW-1:0]       div_cnt_reg;
    tpi_job_t            job_reg;
    logic signed [63:0]  prod_reg;
    logic signed [PW-1:0] ps_reg;
    logic signed [PW-1:0] pe_reg;
    logic [PW-1:0]       den_reg;
    logic [PW-1:0]       rem_reg;
    logic [TW:0]         q_reg;
    logic signed [PRW-1:0] mprod_reg;
    tpi_corner_t         cut_reg;
    logic                hit_reg;
    logic                hc_reg;
    logic                feh_reg;
    logic                skip_reg;
    tpi_res_t            pend_reg;
    logic                pend_vld_reg;
    tpi_res_t            ema_reg;
    tpi_res_t            emb_reg;
    logic                ema_vld_reg;
    logic                emb_vld_reg;

    logic                take;
    logic [1:0]          op_idx;
    tpi_word_t           coef;
    tpi_word_t           coord;
    logic signed [PW-1:0] den_w;
    logic signed [PW-1:0] num_w;
    logic                miss_w;
    logic [PW-1:0]       rem_sh;
    logic [TW+1:0]       q_inc;
    logic [TW-1:0]       t_w;
    logic signed [32:0]  diff_w;
    logic signed [PRW-1:0] rsum_w;
    logic signed [PRW-1:0] rsh_w;
    logic signed [SW-1:0] tot_w;
    tpi_word_t           sat_w;
    logic [2:0]          prev_step;
    logic                acc_s;

    function automatic tpi_res_t mk_res(input logic h, input logic [1:0] ed,
                                        input tpi_corner_t c, input logic [1:0] sh,
                                        input logic two, input logic lst);
        tpi_res_t r;
        r.hit           = h;
        r.edge_res      = ed;
        r.cut           = c;
        r.shared_corner = sh;
        r.two_hits      = two;
        r.last          = lst;
        return r;
    endfunction

    assign take   = (state_reg == S_IDLE) && !jq_empty;
    assign jq_pop = take;

    // operand select for the shared multiplier: S corner first, then E
    always_comb
    begin
        op_idx = (step_reg < 3'd3) ? step_reg[1:0] : 2'(step_reg - 3'd3);
        coef   = plane[op_idx];
        coord  = (step_reg < 3'd3) ? job_reg.s[op_idx] : job_reg.e[op_idx];
    end

    assign prev_step = step_reg - 3'd1;
    assign acc_s     = (prev_step < 3'd3);

    assign den_w  = pe_reg - ps_reg;
    assign num_w  = -ps_reg;
    assign miss_w = (den_reg == '0) || rem_reg[PW-1] || (den_reg < rem_reg);
    assign rem_sh = {rem_reg[PW-2:0], 1'b0};

    assign q_inc = {1'b0, q_reg} + (TW+2)'(1);
    assign t_w   = q_inc[TW:1];

    always_comb
    begin
        diff_w = 33'(signed'(job_reg.e[step_reg])) - 33'(signed'(job_reg.s[step_reg]));
        rsum_w = mprod_reg + PRW'(1 << (FRAC_BITS - 1));
        rsh_w  = rsum_w >>> FRAC_BITS;
        tot_w  = SW'(signed'(job_reg.s[prev_step])) + SW'(rsh_w);
        if (tot_w > SAT_MAX)
        begin
            sat_w = tpi_word_t'(SAT_MAX[31:0]);
        end
        else if (tot_w < SAT_MIN)
        begin
            sat_w = tpi_word_t'(SAT_MIN[31:0]);
        end
        else
        begin
            sat_w = tpi_word_t'(tot_w[31:0]);
        end
    end

    assign of_push = (state_reg == S_EMIT) && !of_full && (ema_vld_reg || emb_vld_reg);
    assign of_res  = ema_vld_reg ? ema_reg : emb_reg;

    // control and sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= 3'd0;
            div_cnt_reg  <= '0;
            hit_reg      <= 1'b0;
            hc_reg       <= 1'b0;
            feh_reg      <= 1'b0;
            skip_reg     <= 1'b0;
            pend_vld_reg <= 1'b0;
            ema_vld_reg  <= 1'b0;
            emb_vld_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    step_reg <= 3'd0;
                    if (take)
                    begin
                        if (jq_job.edge_id == EDGE_20 && skip_reg)
                        begin
                            skip_reg <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd6)
                    begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    div_cnt_reg <= '0;
                    if (miss_w)
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    step_reg    <= 3'd0;
                    if (div_cnt_reg == CW'(FRAC_BITS))
                    begin
                        state_reg <= S_INTERP;
                    end
                end
                S_INTERP:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'(NUM_FIELDS))
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    state_reg <= S_EMIT;
                    case (job_reg.edge_id)
                        EDGE_01:
                        begin
                            hc_reg       <= hit_reg;
                            feh_reg      <= 1'b0;
                            skip_reg     <= 1'b0;
                            pend_vld_reg <= 1'b0;
                            ema_vld_reg  <= hit_reg;
                            emb_vld_reg  <= 1'b0;
                            ema_reg      <= mk_res(1'b1, EDGE_01, cut_reg, CORNER_0,
                                                   1'b0, 1'b0);
                        end
                        EDGE_12:
                        begin
                            emb_vld_reg <= 1'b0;
                            if (hit_reg && hc_reg)
                            begin
                                ema_vld_reg <= 1'b1;
                                ema_reg     <= mk_res(1'b1, EDGE_12, cut_reg, CORNER_1,
                                                      1'b1, 1'b1);
                                hc_reg      <= 1'b0;
                                skip_reg    <= 1'b1;
                            end
                            else if (hit_reg)
                            begin
                                ema_vld_reg  <= 1'b0;
                                hc_reg       <= 1'b1;
                                feh_reg      <= 1'b1;
                                pend_vld_reg <= 1'b1;
                                pend_reg     <= mk_res(1'b1, EDGE_12, cut_reg, CORNER_0,
                                                       1'b0, 1'b0);
                            end
                            else
                            begin
                                ema_vld_reg <= 1'b0;
                            end
                        end
                        default:
                        begin
                            // closing edge 2-0: settle the last flag of the triangle
                            hc_reg       <= 1'b0;
                            pend_vld_reg <= 1'b0;
                            if (hit_reg)
                            begin
                                ema_reg     <= pend_reg;
                                ema_vld_reg <= pend_vld_reg;
                                emb_vld_reg <= 1'b1;
                                emb_reg     <= mk_res(1'b1, EDGE_20, cut_reg,
                                                      (hc_reg && feh_reg) ? CORNER_2
                                                                          : CORNER_0,
                                                      hc_reg, 1'b1);
                            end
                            else if (pend_vld_reg)
                            begin
                                ema_vld_reg <= 1'b1;
                                emb_vld_reg <= 1'b0;
                                ema_reg     <= mk_res(pend_reg.hit, pend_reg.edge_res,
                                                      pend_reg.cut, pend_reg.shared_corner,
                                                      pend_reg.two_hits, 1'b1);
                            end
                            else
                            begin
                                ema_vld_reg <= 1'b1;
                                emb_vld_reg <= 1'b0;
                                ema_reg     <= mk_res(1'b0, EDGE_01, '0, CORNER_0,
                                                      1'b0, 1'b1);
                            end
                        end
                    endcase
                end
                S_EMIT:
                begin
                    if (!of_full)
                    begin
                        if (ema_vld_reg)
                        begin
                            ema_vld_reg <= 1'b0;
                        end
                        else if (emb_vld_reg)
                        begin
                            emb_vld_reg <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= jq_job;
            ps_reg  <= PW'(signed'(plane[REG_PLANE_D])) <<< FRAC_BITS;
            pe_reg  <= PW'(signed'(plane[REG_PLANE_D])) <<< FRAC_BITS;
        end
        if (state_reg == S_MUL)
        begin
            if (step_reg < 3'd6)
            begin
                prod_reg <= 64'(signed'(coef)) * 64'(signed'(coord));
            end
            if (step_reg != 3'd0)
            begin
                if (acc_s)
                begin
                    ps_reg <= ps_reg + PW'(prod_reg);
                end
                else
                begin
                    pe_reg <= pe_reg + PW'(prod_reg);
                end
            end
        end
        if (state_reg == S_PREP)
        begin
            if (den_w[PW-1])
            begin
                den_reg <= -den_w;
                rem_reg <= -num_w;
            end
            else
            begin
                den_reg <= den_w;
                rem_reg <= num_w;
            end
        end
        if (state_reg == S_CHECK)
        begin
            if (rem_reg >= den_reg)
            begin
                q_reg   <= (TW+1)'(1);
                rem_reg <= rem_reg - den_reg;
            end
            else
            begin
                q_reg <= '0;
            end
        end
        if (state_reg == S_DIV)
        begin
            if (rem_sh >= den_reg)
            begin
                rem_reg <= rem_sh - den_reg;
                q_reg   <= {q_reg[TW-1:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[TW-1:0], 1'b0};
            end
        end
        if (state_reg == S_INTERP)
        begin
            if (step_reg < 3'(NUM_FIELDS))
            begin
                mprod_reg <= PRW'(diff_w) * PRW'(signed'({1'b0, t_w}));
            end
            if (step_reg != 3'd0)
            begin
                cut_reg[prev_step] <= sat_w;
            end
        end
    end
endmodule

### rtl/core/triangle_plane_intersection_top.sv
// Top level of the triangle/plane intersection block.
//
// Usage: corners enter one per transaction on the push/full side (x,y,z,u,v in
// signed fixed point with FRAC_BITS fraction bits). Every third corner closes a
// triangle. Edge 0-1 is tested when corner 1 arrives, edges 1-2 and 2-0 when
// corner 2 arrives. Results leave on the empty/pop side, oldest first; the
// final result of a triangle has last set.
// The plane a,b,c,d must be written through cfg_wdata/cfg_addr/cfg_we while the
// block is idle; the block itself does not enforce this. A write takes effect at once.
// An edge test runs in order: plane products on one shared 32x32 multiplier,
// setup, the bit-serial t division, interpolation on a second multiplier, the
// decision and the hand-off; a miss skips the division and interpolation. Edges
// run one at a time, so corner 2 costs the tests of edges 1-2 and 2-0, or of 1-2
// alone when edges 0-1 and 1-2 both hit and edge 2-0 is skipped.
// A job queue of two entries lets corners enter while edges are evaluated;
// a two-entry result queue absorbs receiver stalls. When it fills, the back
// end waits and the job queue and then full back up the input.
// Reset clears the corner count, the hit bookkeeping, queues and plane to zero.
module triangle_plane_intersection_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] tex_u,
    input  logic signed [31:0] tex_v,
    input  logic        pop,
    output logic        empty,
    output logic        hit,
    output logic [1:0]  edge_res,
    output logic signed [31:0] cut_x,
    output logic signed [31:0] cut_y,
    output logic signed [31:0] cut_z,
    output logic signed [31:0] cut_u,
    output logic signed [31:0] cut_v,
    output logic [1:0]  shared_corner,
    output logic        two_hits,
    output logic        last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import tpi_pkg::*;

    tpi_plane_t  plane_reg;
    tpi_corner_t corner;
    logic        jq_push;
    tpi_job_t    jq_wjob;
    logic        jq_full;
    logic        jq_pop;
    tpi_job_t    jq_rjob;
    logic        jq_empty;
    logic        of_push;
    tpi_res_t    of_wres;
    logic        of_full;
    tpi_res_t    of_rres;

    // plane registers, indexed by register number
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else if (cfg_we)
        begin
            plane_reg[cfg_addr] <= cfg_wdata;
        end
    end

    assign corner = '{tex_v, tex_u, pos_z, pos_y, pos_x};

    tpi_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .corner  (corner),
        .jq_push (jq_push),
        .jq_job  (jq_wjob),
        .jq_full (jq_full)
    );

    tpi_fifo #(
        .WIDTH ($bits(tpi_job_t)),
        .DEPTH (2)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (jq_push),
        .wdata (jq_wjob),
        .full  (jq_full),
        .rd_en (jq_pop),
        .rdata (jq_rjob),
        .empty (jq_empty)
    );

    tpi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .plane    (plane_reg),
        .jq_empty (jq_empty),
        .jq_job   (jq_rjob),
        .jq_pop   (jq_pop),
        .of_full  (of_full),
        .of_push  (of_push),
        .of_res   (of_wres)
    );

    tpi_fifo #(
        .WIDTH ($bits(tpi_res_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (of_push),
        .wdata (of_wres),
        .full  (of_full),
        .rd_en (pop),
        .rdata (of_rres),
        .empty (empty)
    );

    assign hit           = of_rres.hit;
    assign edge_res      = of_rres.edge_res;
    assign cut_x         = of_rres.cut[0];
    assign cut_y         = of_rres.cut[1];
    assign cut_z         = of_rres.cut[2];
    assign cut_u         = of_rres.cut[3];
    assign cut_v         = of_rres.cut[4];
    assign shared_corner = of_rres.shared_corner;
    assign two_hits      = of_rres.two_hits;
    assign last          = of_rres.last;
endmodule

### tb/triangle_plane_intersection_top_tb.sv
// Self-checking testbench for the triangle/plane intersection block.
module triangle_plane_intersection_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tpi_pkg::*;

    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic        hit;
        logic [1:0]  edge_res;
        logic [31:0] x, y, z, u, v;
        logic [1:0]  shared_corner;
        logic        two_hits;
        logic        last;
    } cut_rec_t;

    typedef logic signed [31:0] corner_arr_t [5];

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, tex_u = '0, tex_v = '0;
    logic pop = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic full, empty, hit, two_hits, last;
    logic [1:0] edge_res, shared_corner;
    logic signed [31:0] cut_x, cut_y, cut_z, cut_u, cut_v;

    triangle_plane_intersection_top #(.FRAC_BITS(FRAC)) dut (.*);

    always #5 clk = ~clk;

    // Predictor state: plane and triangle bookkeeping.
    logic signed [63:0] pl [4];
    logic signed [63:0] first_c [5];
    logic signed [63:0] prev_c [5];
    int corner_idx = 0;
    int hits_so_far = 0;
    int first_edge = 0;

    cut_rec_t expected_cuts [$];
    corner_arr_t pending_corners [$];
    int errors = 0;
    int cycles = 0;
    bit send_pause = 0;   // sender holds while set
    int hold_pop = 0;     // receiver long hold, in cycles

    function automatic logic signed [127:0] plane_value(logic signed [63:0] c [5]);
        logic signed [127:0] s;
        s = 128'(pl[0]) * 128'(c[0]) + 128'(pl[1]) * 128'(c[1])
          + 128'(pl[2]) * 128'(c[2]) + (128'(pl[3]) <<< FRAC);
        return s;
    endfunction

    function automatic logic signed [63:0] sat(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Edge S->E: returns 1 on a hit, with the interpolated corner in cut.
    function automatic bit cross_edge(logic signed [63:0] s [5], logic signed [63:0] e [5],
                                      output logic [31:0] cut [5]);
        logic signed [127:0] p1, den, num, q;
        logic signed [63:0] t, prod, r;
        p1 = plane_value(s);
        den = plane_value(e) - p1;
        num = -p1;
        for (int i = 0; i < 5; i++) cut[i] = '0;
        if (den == 0) return 0;
        if (den < 0) begin den = -den; num = -num; end
        if (num < 0 || num > den) return 0;
        // floor(num * 2^(F+1) / den), then round halves up to Q1.F
        q = (num <<< (FRAC + 1)) / den;
        t = 64'((q + 1) >>> 1);
        for (int i = 0; i < 5; i++) begin
            prod = (e[i] - s[i]) * t;
            r = (prod + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
            cut[i] = 32'(sat(s[i] + r));
        end
        return 1;
    endfunction

    function automatic cut_rec_t make_cut(bit h, int ed, logic [31:0] c [5],
                                          int sh, bit two, bit lst);
        cut_rec_t r;
        r.hit = h; r.edge_res = ed[1:0];
        r.x = c[0]; r.y = c[1]; r.z = c[2]; r.u = c[3]; r.v = c[4];
        r.shared_corner = sh[1:0]; r.two_hits = two; r.last = lst;
        return r;
    endfunction

    task automatic predict_corner(corner_arr_t inp);
        logic signed [63:0] cur [5];
        logic [31:0] c [5];
        logic [31:0] zero [5];
        int n;
        for (int i = 0; i < 5; i++) begin cur[i] = inp[i]; zero[i] = '0; end
        if (corner_idx == 0) begin
            first_c = cur; prev_c = cur; hits_so_far = 0; first_edge = 0; corner_idx = 1;
        end else if (corner_idx == 1) begin
            if (cross_edge(first_c, cur, c)) begin
                hits_so_far = 1; first_edge = EDGE_01;
                expected_cuts.push_back(make_cut(1, EDGE_01, c, 0, 0, 0));
            end
            prev_c = cur; corner_idx = 2;
        end else begin
            corner_idx = 0; n = 0;
            if (cross_edge(prev_c, cur, c)) begin
                if (hits_so_far == 1) begin
                    expected_cuts.push_back(make_cut(1, EDGE_12, c, CORNER_1, 1, 1));
                    hits_so_far = 0;
                    return;
                end
                hits_so_far = 1; first_edge = EDGE_12; n = 1;
                expected_cuts.push_back(make_cut(1, EDGE_12, c, 0, 0, 0));
            end
            if (cross_edge(cur, first_c, c)) begin
                if (hits_so_far == 1)
                    expected_cuts.push_back(make_cut(1, EDGE_20, c,
                        first_edge == EDGE_12 ? CORNER_2 : CORNER_0, 1, 1));
                else
                    expected_cuts.push_back(make_cut(1, EDGE_20, c, 0, 0, 1));
            end else if (n > 0) begin
                expected_cuts[$].last = 1'b1;
            end else begin
                expected_cuts.push_back(make_cut(0, 0, zero, 0, 0, 1));
            end
            hits_so_far = 0;
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    // Driver: gaps mostly short, sometimes long; push stays high across back-to-back items.
    int send_gap = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (push && !full) begin
                predict_corner('{pos_x, pos_y, pos_z, tex_u, tex_v});
                void'(pending_corners.pop_front());
                send_gap = ($urandom_range(0, 3) == 0) ?
                    (($urandom_range(0, 15) == 0) ? $urandom_range(10, 80)
                                                  : $urandom_range(1, 3)) : 0;
            end
            if (!(push && full)) begin
                if (send_gap > 0) send_gap--;
                if (pending_corners.size() > 0 && send_gap == 0 && !send_pause) begin
                    push <= 1'b1;
                    pos_x <= pending_corners[0][0];
                    pos_y <= pending_corners[0][1];
                    pos_z <= pending_corners[0][2];
                    tex_u <= pending_corners[0][3];
                    tex_v <= pending_corners[0][4];
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each popped transaction, then picks the next pop value.
    always @(posedge clk) begin
        cut_rec_t w;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        if (rst_n) begin
            if (pop && !empty) begin
                if (expected_cuts.size() == 0) begin
                    report_mismatch("unexpected result transaction", 32'(1), 32'(0));
                end else begin
                    w = expected_cuts.pop_front();
                    if (hit !== w.hit) report_mismatch("hit", 32'(hit), 32'(w.hit));
                    if (edge_res !== w.edge_res)
                        report_mismatch("edge_res", 32'(edge_res), 32'(w.edge_res));
                    if (cut_x !== w.x) report_mismatch("cut_x", cut_x, w.x);
                    if (cut_y !== w.y) report_mismatch("cut_y", cut_y, w.y);
                    if (cut_z !== w.z) report_mismatch("cut_z", cut_z, w.z);
                    if (cut_u !== w.u) report_mismatch("cut_u", cut_u, w.u);
                    if (cut_v !== w.v) report_mismatch("cut_v", cut_v, w.v);
                    if (shared_corner !== w.shared_corner)
                        report_mismatch("shared_corner", 32'(shared_corner),
                                        32'(w.shared_corner));
                    if (two_hits !== w.two_hits)
                        report_mismatch("two_hits", 32'(two_hits), 32'(w.two_hits));
                    if (last !== w.last) report_mismatch("last", 32'(last), 32'(w.last));
                end
            end
            if (hold_pop > 0) begin
                hold_pop--;
                pop <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                // occasional stall, rarely a long one
                pop <= 1'b0;
                if ($urandom_range(0, 30) == 0) hold_pop = $urandom_range(10, 60);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic write_plane(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        pl[idx] = $signed(val);
    endtask

    // Block idle: all corners sent, all results drained, back end settled.
    task automatic wait_idle();
        while (pending_corners.size() > 0 || expected_cuts.size() > 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 3) << 16;
            default: return $urandom();
        endcase
    endfunction

    // Small coordinate so many edges straddle the plane; sometimes full range.
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 9) == 0) return rand_word();
        return 32'($signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
    endfunction

    task automatic queue_corner(logic [31:0] x, y, z, u, v);
        pending_corners.push_back('{x, y, z, u, v});
    endtask

    task automatic queue_random_triangles(int n);
        for (int i = 0; i < n; i++)
            for (int k = 0; k < 3; k++)
                queue_corner(rand_coord(), rand_coord(), rand_coord(),
                             rand_word(), rand_word());
    endtask

    initial begin
        for (int i = 0; i < 4; i++) pl[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: plane z = 0 (c = 1.0).
        write_plane(REG_PLANE_A, 32'h0);
        write_plane(REG_PLANE_B, 32'h0);
        write_plane(REG_PLANE_C, 32'h00010000);
        write_plane(REG_PLANE_D, 32'h0);
        // two hits on 0-1 and 1-2 (shared corner 1)
        queue_corner(0, 0, -32'sh10000, 0, 0);
        queue_corner(32'h10000, 0, 32'h10000, 32'h7fffffff, 32'h80000000);
        queue_corner(0, 32'h10000, -32'sh30000, 32'h80000000, 32'h7fffffff);
        // two hits on 1-2 and 2-0 (shared corner 2)
        queue_corner(0, 0, -32'sh10000, 1, 2);
        queue_corner(5, 6, -32'sh20000, 3, 4);
        queue_corner(7, 8, 32'h20000, 9, 10);
        // two hits on 0-1 and 2-0 (shared corner 0), corner on plane
        queue_corner(1, 1, 0, 1, 1);
        queue_corner(2, 2, 32'h10000, 2, 2);
        queue_corner(3, 3, 32'h10000, 3, 3);
        // no hits, edge parallel to plane (zero denominator)
        queue_corner(32'h7fffffff, 32'h80000000, 32'h10000, 0, 0);
        queue_corner(32'h80000000, 32'h7fffffff, 32'h10000, 32'h7fffffff, 0);
        queue_corner(0, 0, 32'h10000, 0, 32'h80000000);
        // extreme values, saturating texture
        queue_corner(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        queue_corner(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        queue_corner(32'hffffffff, 0, 32'h1, 32'h80000000, 32'h7fffffff);
        wait_idle();

        // Random phases over several plane settings, extremes included.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 1) begin
                write_plane(REG_PLANE_A, 32'h7fffffff); write_plane(REG_PLANE_B, 32'h80000000);
                write_plane(REG_PLANE_C, 32'h7fffffff); write_plane(REG_PLANE_D, 32'h80000000);
            end else if (ph == 2) begin
                write_plane(REG_PLANE_A, 32'h0); write_plane(REG_PLANE_B, 32'h0);
                write_plane(REG_PLANE_C, 32'h0); write_plane(REG_PLANE_D, 32'h0);
            end else if (ph > 2) begin
                for (int r = 0; r < 4; r++)
                    write_plane(r[1:0], ($urandom_range(0, 4) == 0) ? rand_word()
                        : 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000));
            end
            if (ph == 4) begin
                // receiver holds off long while sender keeps offering: fills the block
                hold_pop = 400;
            end
            queue_random_triangles(72);
            if (ph == 5) begin
                // sender pauses until everything expected has come back
                while (pending_corners.size() > 100) @(posedge clk);
                send_pause = 1;
                while (expected_cuts.size() > 0 || push) @(posedge clk);
                send_pause = 0;
            end
            wait_idle();
        end

        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
